// ===== design/ilp_pkg.sv =====
package ilp_pkg;

  // Input beat: one character or an end-of-text marker.
  typedef struct packed {
    logic [7:0] character;
    logic       end_of_text;
  } in_t;

  // Result beat: one finished literal.
  typedef struct packed {
    logic [63:0] value;
    logic [2:0]  kind;
    logic        negative;
    logic [2:0]  status;
    logic        terminator_used;
  } out_t;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGNED,
    PH_DIGITS,
    PH_AFTER_U
  } phase_e;

  // Parser state carried between characters.
  typedef struct packed {
    phase_e      phase;
    logic [63:0] magnitude;
    logic        minus_seen;
    logic        hex_mode;
    logic        zero_prefix;
  } state_t;

  // Step result handed from the parser logic to the output register.
  typedef struct packed {
    logic emit;
    out_t res;
  } step_t;

  localparam state_t STATE_RESET = '{
    phase:       PH_START,
    magnitude:   64'd0,
    minus_seen:  1'b0,
    hex_mode:    1'b0,
    zero_prefix: 1'b0
  };

  localparam logic [2:0] K_INT   = 3'd0;
  localparam logic [2:0] K_UINT  = 3'd1;
  localparam logic [2:0] K_LONG  = 3'd2;
  localparam logic [2:0] K_ULONG = 3'd3;
  localparam logic [2:0] K_FLOAT = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DIGIT_EXP = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_TOO_BIG   = 3'd3;
  localparam logic [2:0] ST_FRACTION  = 3'd4;

  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LL    = 8'h6C;
  localparam logic [7:0] CH_UL    = 8'h4C;
  localparam logic [7:0] CH_LU    = 8'h75;
  localparam logic [7:0] CH_UU    = 8'h55;
  localparam logic [7:0] CH_LE    = 8'h65;
  localparam logic [7:0] CH_UE    = 8'h45;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

endpackage

// ===== design/integer_literal_parser.sv =====
// C-style integer literal parser, one character per beat.
// Input channel (in_valid_i / in_ready_o / in_data_i): each beat carries one
// ASCII character, or an end-of-text marker whose character is ignored.
// Output channel (out_valid_o / out_ready_i / out_data_o): one beat per
// finished literal with value, kind, sign, status and whether the ending
// character was part of the literal. Most input beats produce no output.
// A beat that ends a literal passes through the input register and then
// the result register, from which the receiver can take it.
// Throughput: one character per cycle while no emitting character meets a
// full result register; the next character is taken in the cycle after the
// previous one. The path from input register to result register holds one
// 64-bit multiply-by-base-and-add and range compares.
// Reset clears the parser state and both valid flags; the parser starts
// expecting a sign or digit. Each emitted result also returns it to that
// state.
// A stalled receiver holds the result register; a character that would
// emit waits in the input register, and the input register then fills
// and drops in_ready_o. Characters that emit nothing keep flowing.
module integer_literal_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ilp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ilp_pkg::out_t out_data_o
);
  import ilp_pkg::*;

  logic   s1_valid;
  in_t    s1_data;
  logic   advance;
  logic   out_room;
  state_t state_q, state_d;
  state_t nxt_state;
  step_t  step;

  // Hold the accepted character until the parser step can retire it.
  ilp_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .data_i    (in_data_i),
    .valid_o   (s1_valid),
    .advance_i (advance),
    .data_o    (s1_data)
  );

  // One parser step: next state plus an optional result.
  ilp_step u_step (
    .cur_i  (state_q),
    .data_i (s1_data),
    .nxt_o  (nxt_state),
    .step_o (step)
  );

  // Retire the held character unless it emits and the result register is full.
  assign advance = s1_valid && (!step.emit || out_room);
  assign state_d = advance ? nxt_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Result register parts the parser from a stalling receiver.
  ilp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && step.emit),
    .room_o  (out_room),
    .data_i  (step.res),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_data_o)
  );

endmodule

// ===== design/ilp_in_reg.sv =====
module ilp_in_reg (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  output logic         ready_o,
  input  ilp_pkg::in_t data_i,
  output logic         valid_o,
  input  logic         advance_i,
  output ilp_pkg::in_t data_o
);
  import ilp_pkg::*;

  logic valid_q, valid_d;
  in_t  data_q;

  // Take a new beat while empty or whenever the held one leaves in the same cycle.
  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== design/ilp_step.sv =====
module ilp_step (
  input  ilp_pkg::state_t cur_i,
  input  ilp_pkg::in_t    data_i,
  output ilp_pkg::state_t nxt_o,
  output ilp_pkg::step_t  step_o
);
  import ilp_pkg::*;

  logic [7:0]  c;
  logic        eot;
  logic        is_dec, is_hex_letter, is_digit;
  logic [3:0]  dval;
  logic [67:0] prod, acc;
  logic        ovf;
  logic        big_int, big_uint, big_long;
  logic        emit;
  logic [2:0]  kind, status;
  logic        used;
  logic [63:0] val;
  state_t      nxt;

  assign c   = data_i.character;
  assign eot = data_i.end_of_text;

  assign is_dec        = (c >= CH_0) && (c <= CH_9);
  assign is_hex_letter = ((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF));
  assign is_digit      = is_dec || (cur_i.hex_mode && is_hex_letter);
  // Letters a-f and A-F both have low nibble 1..6.
  assign dval          = is_dec ? c[3:0] : c[3:0] + 4'd9;

  // Shift-add multiply by the base, then add the digit; carry-out means overflow.
  assign prod = cur_i.hex_mode ? {cur_i.magnitude, 4'b0000}
                               : ({3'b000, cur_i.magnitude, 1'b0} + {1'b0, cur_i.magnitude, 3'b000});
  assign acc  = prod + {64'd0, dval};
  assign ovf  = |acc[67:64];

  assign big_int  = |cur_i.magnitude[63:31];
  assign big_uint = |cur_i.magnitude[63:32];
  assign big_long = cur_i.magnitude[63];

  always_comb begin
    nxt    = cur_i;
    emit   = 1'b0;
    kind   = K_INT;
    status = ST_OK;
    used   = 1'b0;
    unique case (cur_i.phase)
      PH_START, PH_SIGNED: begin
        if (eot) begin
          emit   = 1'b1;
          status = ST_DIGIT_EXP;
        end else if (cur_i.phase == PH_START && (c == CH_MINUS || c == CH_PLUS)) begin
          nxt.minus_seen = (c == CH_MINUS);
          nxt.phase      = PH_SIGNED;
        end else if (!is_dec) begin
          emit   = 1'b1;
          status = ST_DIGIT_EXP;
        end else begin
          nxt.magnitude   = {60'd0, c[3:0]};
          nxt.zero_prefix = (c == CH_0);
          nxt.phase       = PH_DIGITS;
        end
      end
      PH_DIGITS: begin
        if (eot) begin
          emit   = 1'b1;
          status = big_int ? ST_TOO_BIG : ST_OK;
        end else if (cur_i.zero_prefix && !cur_i.hex_mode && (c == CH_LX || c == CH_UX)) begin
          nxt.hex_mode    = 1'b1;
          nxt.zero_prefix = 1'b0;
        end else if (is_digit) begin
          if (c != CH_0) begin
            nxt.zero_prefix = 1'b0;
          end
          if (ovf) begin
            emit   = 1'b1;
            status = ST_OVERFLOW;
          end else begin
            nxt.magnitude = acc[63:0];
          end
        end else if (c == CH_LL || c == CH_UL) begin
          emit   = 1'b1;
          kind   = K_LONG;
          status = big_long ? ST_TOO_BIG : ST_OK;
          used   = 1'b1;
        end else if (c == CH_LU || c == CH_UU) begin
          nxt.phase = PH_AFTER_U;
        end else if (c == CH_LF || c == CH_UF) begin
          emit = 1'b1;
          kind = K_FLOAT;
          used = 1'b1;
        end else if (c == CH_DOT || c == CH_LE || c == CH_UE) begin
          emit   = 1'b1;
          kind   = K_FLOAT;
          status = ST_FRACTION;
          used   = 1'b1;
        end else begin
          emit   = 1'b1;
          status = big_int ? ST_TOO_BIG : ST_OK;
        end
      end
      PH_AFTER_U: begin
        emit = 1'b1;
        if (!eot && (c == CH_LL || c == CH_UL)) begin
          kind = K_ULONG;
          used = 1'b1;
        end else begin
          kind   = K_UINT;
          status = big_uint ? ST_TOO_BIG : ST_OK;
        end
      end
      default: begin
        nxt = STATE_RESET;
      end
    endcase
    if (emit) begin
      nxt = STATE_RESET;
    end
  end

  always_comb begin
    val = cur_i.minus_seen ? (64'd0 - cur_i.magnitude) : cur_i.magnitude;
    if (status != ST_OK) begin
      val = 64'd0;
    end
    if (kind == K_INT || kind == K_UINT) begin
      val[63:32] = 32'd0;
    end
  end

  assign nxt_o                      = nxt;
  assign step_o.emit                = emit;
  assign step_o.res.value           = val;
  assign step_o.res.kind            = kind;
  assign step_o.res.negative        = cur_i.minus_seen;
  assign step_o.res.status          = status;
  assign step_o.res.terminator_used = used;

endmodule

// ===== design/ilp_out_reg.sv =====
module ilp_out_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  output logic          room_o,
  input  ilp_pkg::out_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output ilp_pkg::out_t data_o
);
  import ilp_pkg::*;

  logic valid_q, valid_d;
  out_t data_q;

  // Room while empty or while the held beat is taken this cycle.
  assign room_o  = !valid_q || ready_i;
  assign valid_d = load_i ? 1'b1 : (ready_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== verif/testbench.sv =====
module testbench;
  import ilp_pkg::*;

  // Tracks the parser state beat by beat and queues the result that each
  // finished literal must produce, then checks result beats against the queue.
  class literal_checker;
    localparam logic [63:0] INT_LIMIT  = 64'h0000_0000_7FFF_FFFF;
    localparam logic [63:0] UINT_LIMIT = 64'h0000_0000_FFFF_FFFF;
    localparam logic [63:0] LONG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    phase_e      ph;
    logic [63:0] mag;
    bit          minus;
    bit          hexm;
    bit          zpref;
    out_t        pending[$];
    int unsigned mismatches;

    function new();
      clear();
      mismatches = 0;
    endfunction

    function void clear();
      ph    = PH_START;
      mag   = '0;
      minus = 1'b0;
      hexm  = 1'b0;
      zpref = 1'b0;
    endfunction

    function void finish_literal(logic [2:0] kind, logic [2:0] st, bit used);
      out_t r;
      r.value = '0;
      if (st == ST_OK) begin
        r.value = minus ? (64'd0 - mag) : mag;
        if (kind == K_INT || kind == K_UINT) r.value[63:32] = '0;
      end
      r.kind            = kind;
      r.negative        = minus;
      r.status          = st;
      r.terminator_used = used;
      pending.push_back(r);
      clear();
    endfunction

    function void finish_ranged(logic [2:0] kind, logic [63:0] limit, bit used);
      finish_literal(kind, (mag > limit) ? ST_TOO_BIG : ST_OK, used);
    endfunction

    function int digit_of(logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c) - int'(CH_0);
      if (hexm && c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
      if (hexm && c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
      return -1;
    endfunction

    // Advance the parser by one accepted input beat.
    function void note_beat(in_t b);
      logic [7:0]  c;
      bit          eot;
      int          d;
      logic [67:0] grown;
      c   = b.character;
      eot = b.end_of_text;
      case (ph)
        PH_START, PH_SIGNED: begin
          if (eot) begin
            finish_literal(K_INT, ST_DIGIT_EXP, 1'b0);
          end else if (ph == PH_START && (c == CH_MINUS || c == CH_PLUS)) begin
            minus = (c == CH_MINUS);
            ph    = PH_SIGNED;
          end else if (c < CH_0 || c > CH_9) begin
            finish_literal(K_INT, ST_DIGIT_EXP, 1'b0);
          end else begin
            mag   = 64'(c - CH_0);
            zpref = (c == CH_0);
            ph    = PH_DIGITS;
          end
        end
        PH_DIGITS: begin
          d = digit_of(c);
          if (eot) begin
            finish_ranged(K_INT, INT_LIMIT, 1'b0);
          end else if (zpref && !hexm && (c == CH_LX || c == CH_UX)) begin
            hexm  = 1'b1;
            zpref = 1'b0;
          end else if (d >= 0) begin
            if (c != CH_0) zpref = 1'b0;
            grown = {4'd0, mag} * (hexm ? 68'd16 : 68'd10) + 68'(d);
            if (grown[67:64] != 4'd0) finish_literal(K_INT, ST_OVERFLOW, 1'b0);
            else mag = grown[63:0];
          end else if (c == CH_LL || c == CH_UL) begin
            finish_ranged(K_LONG, LONG_LIMIT, 1'b1);
          end else if (c == CH_LU || c == CH_UU) begin
            ph = PH_AFTER_U;
          end else if (c == CH_LF || c == CH_UF) begin
            finish_literal(K_FLOAT, ST_OK, 1'b1);
          end else if (c == CH_DOT || c == CH_LE || c == CH_UE) begin
            finish_literal(K_FLOAT, ST_FRACTION, 1'b1);
          end else begin
            finish_ranged(K_INT, INT_LIMIT, 1'b0);
          end
        end
        default: begin
          if (!eot && (c == CH_LL || c == CH_UL)) finish_literal(K_ULONG, ST_OK, 1'b1);
          else finish_ranged(K_UINT, UINT_LIMIT, 1'b0);
        end
      endcase
    endfunction

    // Compare one result beat with the oldest queued literal.
    function void check_literal(out_t got);
      out_t want;
      bit   orphan;
      bit   bad;
      want   = '0;
      orphan = (pending.size() == 0);
      bad    = orphan;
      if (!orphan) begin
        want = pending.pop_front();
        bad  = (got.value !== want.value) || (got.kind !== want.kind) ||
               (got.negative !== want.negative) || (got.status !== want.status) ||
               (got.terminator_used !== want.terminator_used);
      end
      if (bad) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%s result beat: want value=%h kind=%0d neg=%0b status=%0d used=%0b",
                   orphan ? "unexpected" : "wrong", want.value, want.kind, want.negative,
                   want.status, want.terminator_used);
          $display("  got value=%h kind=%0d neg=%0b status=%0d used=%0b",
                   got.value, got.kind, got.negative, got.status, got.terminator_used);
        end
      end
    endfunction
  endclass

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned PHASE_BEATS = 340;
  localparam logic [7:0]  CH_SPACE    = 8'h20;
  localparam logic [7:0]  CH_SEMI     = 8'h3B;
  localparam logic [7:0]  CH_BANG     = 8'h21;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  literal_checker chk;

  // Idling knobs, set by the stimulus process per phase.
  int unsigned gap_pct       = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned sent          = 0;
  int unsigned cycles        = 0;

  // Literals sitting on or just past the limits of each kind and of 64 bits.
  string limit_texts[17] = '{
    "2147483647", "2147483648", "4294967295", "4294967296",
    "9223372036854775807", "9223372036854775808",
    "18446744073709551615", "18446744073709551616", "99999999999999999999",
    "0x7fffffff", "0x80000000", "0xFFFFFFFF", "0x100000000",
    "0x7FFFFFFFFFFFFFFF", "0x8000000000000000", "0xffffffffffffffff",
    "0x10000000000000000"
  };

  integer_literal_parser dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always #6 clk = ~clk;

  // Watchdog: give up if the run drags on far past any sane length.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Sample both channels at the rising edge; note the input beat first so
  // the expectation queue always holds it before any result could match.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_valid && in_ready) chk.note_beat(in_data);
      if (out_valid && out_ready) chk.check_literal(out_data);
    end
  end

  // Receiver: stall at random, or hold off completely for a long stretch
  // whenever the stimulus process asks for it.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one beat from a falling edge, hold it until accepted, then idle
  // at random. Valid is only lowered when a gap is actually taken.
  task automatic send_beat(input logic [7:0] c, input bit eot);
    in_valid <= 1'b1;
    in_data  <= '{character: c, end_of_text: eot};
    do @(posedge clk); while (in_ready !== 1'b1);
    @(negedge clk);
    sent++;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic send_text(input string s, input bit close_with_end);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
    if (close_with_end) send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  // Build one literal with random content, suffix and ending.
  task automatic send_random_literal();
    logic [7:0] text[$];
    int         pick;
    int         n;
    int         r;
    bit         closed;
    string      lt;
    closed = 1'b0;
    pick = $urandom_range(99);
    if (pick < 30) text.push_back(CH_MINUS);
    else if (pick < 45) text.push_back(CH_PLUS);

    pick = $urandom_range(99);
    if (pick < 15) begin
      lt = limit_texts[$urandom_range(16)];
      for (int i = 0; i < lt.len(); i++) text.push_back(lt[i]);
    end else if (pick < 45) begin
      // hex: a run of zeros, the x, then mostly short digit runs
      n = $urandom_range(1, 3);
      repeat (n) text.push_back(CH_0);
      text.push_back($urandom_range(1) ? CH_LX : CH_UX);
      n = ($urandom_range(99) < 15) ? $urandom_range(14, 18) : $urandom_range(0, 9);
      repeat (n) begin
        r = $urandom_range(21);
        if (r < 10) text.push_back(CH_0 + 8'(r));
        else if (r < 16) text.push_back(CH_LA + 8'(r - 10));
        else text.push_back(CH_UA + 8'(r - 16));
      end
    end else begin
      n = ($urandom_range(99) < 15) ? $urandom_range(9, 22) : $urandom_range(1, 8);
      repeat (n) text.push_back(CH_0 + 8'($urandom_range(9)));
    end

    pick = $urandom_range(99);
    if (pick < 35) begin
      // no suffix
    end else if (pick < 45) begin
      text.push_back($urandom_range(1) ? CH_LL : CH_UL);
      closed = 1'b1;
    end else if (pick < 55) begin
      text.push_back($urandom_range(1) ? CH_LU : CH_UU);
    end else if (pick < 65) begin
      text.push_back($urandom_range(1) ? CH_LU : CH_UU);
      text.push_back($urandom_range(1) ? CH_LL : CH_UL);
      closed = 1'b1;
    end else if (pick < 73) begin
      text.push_back($urandom_range(1) ? CH_LF : CH_UF);
      closed = 1'b1;
    end else if (pick < 81) begin
      r = $urandom_range(2);
      text.push_back(r == 0 ? CH_DOT : (r == 1 ? CH_LE : CH_UE));
      closed = 1'b1;
    end

    foreach (text[i]) send_beat(text[i], 1'b0);

    // End the literal; a literal closed by its suffix mostly needs nothing.
    if (!closed || $urandom_range(99) < 20) begin
      pick = $urandom_range(99);
      if (pick < 30) send_beat(8'($urandom_range(255)), 1'b1);
      else if (pick < 60) send_beat(CH_SPACE, 1'b0);
      else if (pick < 75) send_beat(CH_SEMI, 1'b0);
      else send_beat(8'($urandom_range(255)), 1'b0);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_beat(8'($urandom_range(255)), $urandom_range(3) == 0);
  endtask

  // Drop valid so the last beat is not offered again, then wait for results.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (chk.pending.size() != 0) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned stall);
    int unsigned target;
    gap_pct   = gap;
    stall_pct = stall;
    target    = sent + PHASE_BEATS;
    while (sent < target) begin
      if ($urandom_range(99) < 12) send_noise();
      else send_random_literal();
    end
  endtask

  initial begin
    chk      = new();
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: byte extremes and an end marker at the start, sign without
    // digits, unsigned long with a minus, empty hex, fraction, float, long,
    // unsigned closed by end of text, and unsigned closed by a stray dot.
    send_beat(8'hFF, 1'b1);
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_text("-.", 1'b0);
    send_text("+", 1'b1);
    send_text("-7ul", 1'b0);
    send_text("0xg", 1'b0);
    send_text("5.", 1'b0);
    send_text("3F", 1'b0);
    send_text("-9L", 1'b0);
    send_text("12U", 1'b1);
    send_text("0Xau.", 1'b0);
    wait_drained();

    run_phase(0, 0);

    // Hold the receiver off while every beat ends a literal, so the parser
    // backs up and stalls its input; then pause until all results are in.
    hold_requests++;
    repeat (40) send_beat(CH_BANG, 1'b0);
    wait_drained();

    run_phase(78, 0);
    wait_drained();
    run_phase(0, 78);
    wait_drained();
    run_phase(10, 10);

    gap_pct   = 0;
    stall_pct = 0;
    wait_drained();
    repeat (20) @(negedge clk);

    if (chk.mismatches == 0 && chk.pending.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== integer_literal_parser.f =====
design/ilp_pkg.sv
design/ilp_in_reg.sv
design/ilp_step.sv
design/ilp_out_reg.sv
design/integer_literal_parser.sv
verif/testbench.sv
